// ===== rtl/rut_pkg.sv =====
// ----------------------------------------------------------------------------
// rut_pkg: shared definitions for the terminator-delimited frame receiver
// Holds the default sizes, register reset values, register indexes and the
// result record that the receiver core produces.
// ----------------------------------------------------------------------------
package rut_pkg;

	// Default frame buffer capacity in bytes and longest terminator in bytes.
	localparam int CAPACITY = 31;
	localparam int MAX_TERM = 8;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Register reset values: a single line feed terminates a frame.
	localparam logic [3:0]            TERM_LEN_RESET   = 4'd1;
	localparam logic [CFG_DATA_W-1:0] TERM_BYTES_RESET = 64'd10;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TERM_LENGTH = 2'd0,
		CFG_TERM_BYTES  = 2'd1
	} cfg_reg_t;

	// Why a frame ended on a given byte.
	typedef enum logic [1:0] {
		REASON_NONE  = 2'd0,
		REASON_MATCH = 2'd1,
		REASON_FULL  = 2'd2
	} reason_t;

	// One result item as it leaves the core.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [4:0] position;
		logic       frame_end;
		reason_t    end_reason;
	} result_t;

endpackage

// ===== rtl/receive_until_terminator_core.sv =====
// ----------------------------------------------------------------------------
// receive_until_terminator_core: terminator-delimited frame receiver
// Tags every received byte with its position in the current frame and flags
// the byte that ends the frame, either on a terminator match or when the
// frame buffer capacity is reached.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   input    in_valid / in_stall    rx_byte
//   output   out_valid / out_stall  out_byte, position, frame_end, end_reason
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A new request can be taken in every cycle while in_stall is low. Its
// result goes to the output register, or to the skid register while it is held.
// The per-byte work is a parallel compare of the shifted byte window against
// the terminator plus one counter increment, all ahead of the output register.
// Reset clears the frame counter, the byte window, and the registers to a
// one-byte line feed terminator.
// A skid register behind the output register keeps one extra result, so a
// request is still taken while an earlier result waits; in_stall rises only
// when both are occupied, and it comes straight from a flip-flop.
// The configuration port is always ready; a write to an unknown index is
// dropped.

module receive_until_terminator_core #(
	parameter int CAPACITY = rut_pkg::CAPACITY,
	parameter int MAX_TERM = rut_pkg::MAX_TERM
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic [4:0]                     position,
	output logic                           frame_end,
	output logic [1:0]                     end_reason,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rut_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rut_pkg::CFG_DATA_W-1:0] cfg_data
);

	// The counter holds 0 .. CAPACITY-1; the incremented value needs one bit more.
	localparam int CntW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int WinW = MAX_TERM * 8;

	// Configuration registers. Only the terminator bytes that can ever be
	// compared are kept.
	logic [3:0]               term_len_q;
	logic [MAX_TERM-1:0][7:0] term_q;

	// Frame state.
	logic [CntW-1:0]          cnt_q;
	logic [MAX_TERM-1:0][7:0] win_q;

	// Output register and skid register.
	rut_pkg::result_t out_q;
	rut_pkg::result_t skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	// Per-request datapath.
	logic                     acc;
	logic                     take;
	logic [3:0]               eff_len;
	logic [CntW:0]            cnt_nxt;
	logic [MAX_TERM-1:0][7:0] win_nxt;
	logic [MAX_TERM-1:0]      lane_ok;
	logic                     len_ok;
	logic                     is_match;
	logic                     is_full;
	logic [CntW+4:0]          pos_wide;
	rut_pkg::result_t         res;

	logic load_out_skid;
	logic load_out_in;
	logic load_skid;

	assign cfg_ready = 1'b1;

	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !in_stall;
	assign take     = out_valid_q && !out_stall;

	// Clamp the terminator length into 1 .. MAX_TERM.
	always_comb begin
		if (term_len_q == 4'd0) begin
			eff_len = 4'd1;
		end else if (int'(term_len_q) > MAX_TERM) begin
			eff_len = 4'(MAX_TERM);
		end else begin
			eff_len = term_len_q;
		end
	end

	// Shift the new byte into the window, newest in lane 0, and compare each
	// lane that lies inside the terminator. Lanes beyond it always agree.
	always_comb begin
		win_nxt[0] = rx_byte;
		for (int i = 1; i < MAX_TERM; i++) begin
			win_nxt[i] = win_q[i-1];
		end
		for (int i = 0; i < MAX_TERM; i++) begin
			lane_ok[i] = (i >= int'(eff_len)) || (win_nxt[i] == term_q[i]);
		end
	end

	assign cnt_nxt = {1'b0, cnt_q} + (CntW+1)'(1);

	// A match needs the frame to hold at least as many bytes as the
	// terminator, so bytes of an earlier frame never take part.
	assign len_ok   = int'(cnt_nxt) >= int'(eff_len);
	assign is_match = len_ok && (&lane_ok);
	assign is_full  = cnt_nxt >= (CntW+1)'(CAPACITY);

	assign pos_wide = (CntW+5)'(cnt_q);

	// A match wins over a full buffer when both happen on the same byte.
	always_comb begin
		res.out_byte = rx_byte;
		res.position = pos_wide[4:0];
		if (is_match) begin
			res.frame_end  = 1'b1;
			res.end_reason = rut_pkg::REASON_MATCH;
		end else if (is_full) begin
			res.frame_end  = 1'b1;
			res.end_reason = rut_pkg::REASON_FULL;
		end else begin
			res.frame_end  = 1'b0;
			res.end_reason = rut_pkg::REASON_NONE;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_len_q <= rut_pkg::TERM_LEN_RESET;
			term_q     <= rut_pkg::TERM_BYTES_RESET[WinW-1:0];
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rut_pkg::CFG_TERM_LENGTH: begin
					term_len_q <= cfg_data[3:0];
				end
				rut_pkg::CFG_TERM_BYTES: begin
					term_q <= cfg_data[WinW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Frame state: the byte that ends a frame clears the counter and window,
	// so the next byte starts again at position zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			win_q <= '0;
		end else if (acc) begin
			if (res.frame_end) begin
				cnt_q <= '0;
				win_q <= '0;
			end else begin
				cnt_q <= cnt_nxt[CntW-1:0];
				win_q <= win_nxt;
			end
		end
	end

	// The output register refills from the skid register first; a new result
	// goes to the skid register only while the output register is held.
	assign load_out_skid = (take || !out_valid_q) && skid_valid_q;
	assign load_out_in   = (take || !out_valid_q) && !skid_valid_q && acc;
	assign load_skid     = out_valid_q && !take && acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take || !out_valid_q) begin
				out_valid_q <= skid_valid_q || acc;
			end
			if (load_out_skid) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_q <= skid_q;
		end else if (load_out_in) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_q.out_byte;
	assign position   = out_q.position;
	assign frame_end  = out_q.frame_end;
	assign end_reason = out_q.end_reason;

	// The skid register is only ever occupied behind a full output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	// The end flag and the reason code always agree.
	a_end_flag_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.frame_end == (out_q.end_reason != rut_pkg::REASON_NONE)))
		else $error("frame_end disagrees with end_reason");

	// A byte that ends a frame restarts the count at zero.
	a_restart_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.frame_end) |=> (cnt_q == '0))
		else $error("frame counter not cleared after a frame end");

	// The frame counter never reaches the capacity.
	a_count_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) < CAPACITY)
		else $error("frame counter reached the buffer capacity");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the terminator-delimited frame receiver
// Streams bytes through the core under several terminator settings and
// idling mixes. A behavioral copy of the frame logic predicts the tag of
// every accepted byte, and each tag that leaves the core is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	// Indexes past the end of the register list. The core must drop writes
	// to them without touching the real registers.
	localparam logic [rut_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [rut_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// Cycles without any accepted request before the run is declared hung.
	// Even at the heaviest idling a gap of this length is vanishingly rare.
	localparam int WATCHDOG_LIMIT = 4000;

	// Items per terminator setting in the random part.
	localparam int ITEMS_PER_SETTING = 88;
	localparam int SETTINGS_PER_PHASE = 4;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic                           in_stall;
	logic [7:0]                     rx_byte    = 8'h00;
	logic                           out_valid;
	logic                           out_stall  = 1'b0;
	logic [7:0]                     out_byte;
	logic [4:0]                     position;
	logic                           frame_end;
	logic [1:0]                     end_reason;
	logic                           cfg_valid  = 1'b0;
	logic                           cfg_ready;
	logic [rut_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [rut_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

	// Shadow of the core's registers and frame state, kept in step with every
	// accepted write and every accepted byte.
	logic [3:0]  term_len_cfg = rut_pkg::TERM_LEN_RESET;
	logic [63:0] term_seq_cfg = rut_pkg::TERM_BYTES_RESET;
	int unsigned frame_len    = 0;
	logic [63:0] byte_window  = '0;

	// Predicted tags waiting for the core to produce them, oldest first.
	rut_pkg::result_t expected_tags[$];

	// Idling mix of the current phase, in percent.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	always #1 clk = ~clk;

	receive_until_terminator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.position   (position),
		.frame_end  (frame_end),
		.end_reason (end_reason),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// The terminator length actually compared: a zero length acts as one
	// byte, and anything longer than the window acts as the full window.
	function automatic int unsigned term_span();
		int unsigned n;
		n = term_len_cfg;
		if (n < 1) n = 1;
		if (n > rut_pkg::MAX_TERM) n = rut_pkg::MAX_TERM;
		return n;
	endfunction

	// Works out the tag of one accepted byte and advances the shadow frame
	// state. The window only counts once the frame holds at least a full
	// terminator, so bytes of the previous frame never complete a match. A
	// byte that both matches and fills the buffer reports the match.
	function automatic rut_pkg::result_t tag_byte(input logic [7:0] b);
		rut_pkg::result_t tag;
		int unsigned      span;
		int unsigned      count;
		logic [63:0]      mask;
		span = term_span();
		mask = (span >= 8) ? '1 : ((64'd1 << (span * 8)) - 64'd1);
		tag.out_byte = b;
		tag.position = frame_len[4:0];
		byte_window = {byte_window[55:0], b};
		count = frame_len + 1;
		if (count >= span && (byte_window & mask) == (term_seq_cfg & mask))
			tag.end_reason = rut_pkg::REASON_MATCH;
		else if (count >= rut_pkg::CAPACITY)
			tag.end_reason = rut_pkg::REASON_FULL;
		else
			tag.end_reason = rut_pkg::REASON_NONE;
		tag.frame_end = (tag.end_reason != rut_pkg::REASON_NONE);
		if (tag.frame_end) begin
			frame_len = 0;
			byte_window = '0;
		end else begin
			frame_len = count;
		end
		return tag;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_count < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Receiver side: the stall decision is redrawn every cycle at the falling
	// edge so that back-pressure can land on any phase of the core's work.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result checker: every tag accepted at a rising edge is matched against
	// the oldest prediction. A tag with nothing predicted is a failure too.
	always @(posedge clk) begin
		rut_pkg::result_t got;
		rut_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.out_byte   = out_byte;
			got.position   = position;
			got.frame_end  = frame_end;
			got.end_reason = rut_pkg::reason_t'(end_reason);
			if (expected_tags.size() == 0) begin
				note_failure($sformatf(
					"unexpected tag byte=%02h pos=%0d end=%0d reason=%0d",
					got.out_byte, got.position, got.frame_end, got.end_reason));
			end else begin
				want = expected_tags.pop_front();
				if (got !== want)
					note_failure($sformatf({
						"expected byte=%02h pos=%0d end=%0d reason=%0d, ",
						"got byte=%02h pos=%0d end=%0d reason=%0d"},
						want.out_byte, want.position, want.frame_end, want.end_reason,
						got.out_byte, got.position, got.frame_end, got.end_reason));
			end
		end
	end

	// Watchdog: counts cycles in which no channel moves a request. A hung
	// core, or a result that never arrives, ends the run here.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Sends one byte. Entered in any state; it leaves at the rising edge at
	// which the byte was taken, with in_valid still high. The next driver of
	// the input channel decides at the following falling edge whether valid
	// stays up, so it is never lowered and raised in the same step.
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_tags.push_back(tag_byte(b));
	endtask

	// Lowers the input request and waits until every predicted tag has come
	// back, then lets the output and skid registers settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_tags.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register write; the shadow copy is updated when the core takes it.
	// cfg_valid is left high; the caller lowers it once its writes are done.
	task automatic write_reg(input logic [rut_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == rut_pkg::CFG_TERM_LENGTH)
			term_len_cfg = data[3:0];
		else if (idx == rut_pkg::CFG_TERM_BYTES)
			term_seq_cfg = data;
	endtask

	// Changes the terminator while the core is idle. The unused upper bits of
	// the length write carry random data, and one write goes to a spare index
	// so that ignored writes are exercised with every setting.
	task automatic apply_setting(input logic [3:0] len, input logic [63:0] seq);
		logic [63:0] len_word;
		logic [63:0] junk;
		len_word = {$urandom, $urandom};
		len_word[3:0] = len;
		junk = {$urandom, $urandom};
		drain_results();
		write_reg(rut_pkg::CFG_TERM_LENGTH, len_word);
		write_reg(rut_pkg::CFG_TERM_BYTES, seq);
		write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, junk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The reset terminator is a single line feed: it must end a frame even
	// as the very first byte, and zero and all-ones bytes are plain data.
	task automatic test_line_feed_default();
		send_byte(8'h0A);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h41);
		send_byte(8'h0A);
	endtask

	// An all-zero eight-byte terminator. The cleared window already holds
	// zeros, so only the byte count keeps the first seven from matching.
	task automatic test_zero_terminator();
		apply_setting(4'd8, 64'h0);
		repeat (9) send_byte(8'h00);
	endtask

	// Out-of-range lengths: zero behaves as one byte and fifteen as eight.
	task automatic test_length_clamp();
		apply_setting(4'd0, 64'hFFFF_FFFF_FFFF_FF55);
		send_byte(8'h55);
		send_byte(8'hAA);
		apply_setting(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
		repeat (8) send_byte(8'hFF);
	endtask

	// Random traffic under several terminator settings. Most of it is
	// well-formed frames that end on the terminator; some of it breaks off
	// after part of the terminator, and some is plain noise that tends to
	// run into the buffer limit. Payload lengths range up to the capacity so
	// that a terminator completing on the last free slot also occurs.
	task automatic test_random_frames(input int unsigned idle_pct,
			input int unsigned stall_pct);
		logic [3:0]  len;
		logic [63:0] seq;
		int unsigned sent;
		int unsigned kind;
		int unsigned payload;
		int unsigned span;
		int unsigned cut;
		int unsigned pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
			if (s == 0) len = 4'd1;
			else if (s == 1) len = 4'd8;
			else len = 4'($urandom_range(15));
			for (int k = 0; k < 8; k++) begin
				pick = $urandom_range(7);
				seq[8*k +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
			end
			apply_setting(len, seq);
			span = term_span();
			sent = 0;
			while (sent < ITEMS_PER_SETTING) begin
				kind = $urandom_range(99);
				payload = ($urandom_range(9) < 7) ? $urandom_range(8) : $urandom_range(9, 30);
				if (kind < 75) begin
					cut = span;
				end else if (kind < 90) begin
					cut = (span > 1) ? $urandom_range(1, span - 1) : 0;
				end else begin
					cut = 0;
					payload = $urandom_range(8, 40);
				end
				repeat (payload) send_byte(8'($urandom));
				// Terminator bytes go out oldest first, so the final one
				// (held in the low byte) is sent last.
				for (int k = span - 1; k >= int'(span - cut); k--)
					send_byte(term_seq_cfg[8*k +: 8]);
				sent += payload + cut;
			end
		end
	endtask

	initial begin
		// Reset is held low at the start and released at a falling edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_line_feed_default();
		test_zero_terminator();
		test_length_clamp();

		test_random_frames(0, 0);
		test_random_frames(87, 0);
		test_random_frames(0, 87);
		test_random_frames(22, 22);

		drain_results();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
